@@ hw/rtl/ppm_pkg.sv @@
// ppm_pkg: shared widths and register codes for the packet pattern matcher.
// No dependencies; imported by ppm_match_cell and packet_pattern_matcher_unit.
package ppm_pkg;

    // Fixed field and register widths
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int OFFSET_W     = 16;
    localparam int PATTERN_SLOTS = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } t_cfg_reg;

endpackage

@@ hw/rtl/packet_pattern_matcher_unit.sv @@
// packet_pattern_matcher_unit: top level of the packet pattern matcher.
// Depends on ppm_pkg and ppm_match_cell.
//
// Scans packets one byte per clock for the first occurrence of a configured
// pattern of 1 to 16 bytes and returns one result per packet: found with the
// match start offset, or not found when the last byte arrives without a match.
// A row of match cells, one per pattern byte, each records whether the
// pattern prefix ending there matches the most recent bytes and passes that
// bit to its neighbor on every accepted byte, so the row sustains a byte per
// clock. A result lands in an output register; the input stalls only while
// that register holds a result the sink is stalling.
// Configuration writes clear the match cells but keep the packet offset.
module packet_pattern_matcher_unit #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int MAX_PACKET_BYTES  = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppm_pkg::CFG_W-1:0]     i_cfg_wdata,
    // byte input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ppm_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last_byte,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [ppm_pkg::OFFSET_W-1:0]  o_start_offset
);
    import ppm_pkg::*;

    localparam int NCELL = (MAX_PATTERN_BYTES < PATTERN_SLOTS) ? MAX_PATTERN_BYTES
                                                               : PATTERN_SLOTS;
    localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int POS_LIMIT = (MAX_PACKET_BYTES < (1 << OFFSET_W)) ? MAX_PACKET_BYTES
                                                                    : (1 << OFFSET_W);
    localparam int POS_W = $clog2(POS_LIMIT);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIMIT - 1);

    // Configuration registers
    logic [LEN_W-1:0]          r_pattern_length;
    logic [CFG_W-1:0]          r_pattern_low;
    logic [CFG_W-1:0]          r_pattern_high;
    logic                      cfg_hit;

    // Per-packet state
    logic [POS_W-1:0]          r_byte_pos;
    logic [POS_W-1:0]          n_byte_pos;
    logic                      r_reported;
    logic                      n_reported;

    // Output register
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_found;
    logic                      n_found;
    logic [OFFSET_W-1:0]       r_start_offset;
    logic [OFFSET_W-1:0]       n_start_offset;

    logic                      in_xfer;
    logic                      cell_clear;
    logic [2*CFG_W-1:0]        pattern_all;
    logic [NCELL-1:0]          hits;
    logic [NCELL-1:0]          cell_match;
    logic [LEN_W-1:0]          used_len;
    logic [LEN_W-1:0]          tap_full;
    logic                      full_match;
    logic [OFFSET_W:0]         end_count;
    logic [OFFSET_W:0]         used_len_ext;
    logic [OFFSET_W-1:0]       match_offset;

    // Register writes; indexes beyond the list are dropped
    always_comb begin
        unique case (t_cfg_reg'(i_cfg_index))
            REG_PATTERN_LENGTH,
            REG_PATTERN_LOW,
            REG_PATTERN_HIGH:   cfg_hit = i_cfg_we;
            default:            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_W'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= i_cfg_wdata;
                REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Length in use: zero reads as one, large values clamp to the cell count
    always_comb begin
        if (r_pattern_length == '0) begin
            used_len = LEN_W'(1);
        end else if (r_pattern_length > LEN_W'(NCELL)) begin
            used_len = LEN_W'(NCELL);
        end else begin
            used_len = r_pattern_length;
        end
    end
    assign tap_full = used_len - LEN_W'(1);

    // Input handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign cell_clear = cfg_hit || (in_xfer && i_last_byte);

    // Cell chain, one cell per pattern byte
    assign pattern_all = {r_pattern_high, r_pattern_low};

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic prev_match;
        if (k == 0) begin : g_head
            assign prev_match = 1'b1;
        end else begin : g_link
            assign prev_match = cell_match[k-1];
        end
        ppm_match_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_clear        (cell_clear),
            .i_step         (in_xfer),
            .i_prev_match   (prev_match),
            .i_data_byte    (i_data_byte),
            .i_pattern_byte (pattern_all[k*BYTE_W +: BYTE_W]),
            .o_hit          (hits[k]),
            .o_match        (cell_match[k])
        );
    end

    assign full_match = hits[tap_full[IDX_W-1:0]] && !r_reported;

    // Start offset = position + 1 - length, floored at zero
    assign end_count    = (OFFSET_W+1)'(r_byte_pos) + (OFFSET_W+1)'(1);
    assign used_len_ext = (OFFSET_W+1)'(used_len);
    always_comb begin
        if (end_count >= used_len_ext) begin
            match_offset = OFFSET_W'(end_count - used_len_ext);
        end else begin
            match_offset = '0;
        end
    end

    // Per-packet state and result register
    always_comb begin
        n_byte_pos     = r_byte_pos;
        n_reported     = r_reported;
        n_out_valid    = r_out_valid && i_out_stall;
        n_found        = r_found;
        n_start_offset = r_start_offset;
        if (in_xfer) begin
            if (!r_reported) begin
                if (full_match) begin
                    n_out_valid    = 1'b1;
                    n_found        = 1'b1;
                    n_start_offset = match_offset;
                    n_reported     = 1'b1;
                end else if (i_last_byte) begin
                    n_out_valid    = 1'b1;
                    n_found        = 1'b0;
                    n_start_offset = '0;
                end
                n_byte_pos = (r_byte_pos < POS_MAX) ? r_byte_pos + POS_W'(1) : POS_MAX;
            end
            if (i_last_byte) begin
                n_byte_pos = '0;
                n_reported = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_reported  <= n_reported;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found        <= n_found;
        r_start_offset <= n_start_offset;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_start_offset = r_start_offset;

endmodule

@@ hw/rtl/ppm_match_cell.sv @@
// ppm_match_cell: one position of the prefix-match chain; holds whether the
// pattern prefix ending at this position matches the latest bytes. Uses ppm_pkg.
module ppm_match_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_step,
    input  logic                      i_prev_match,
    input  logic [ppm_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [ppm_pkg::BYTE_W-1:0] i_pattern_byte,
    output logic                      o_hit,
    output logic                      o_match
);
    import ppm_pkg::*;

    logic r_match;
    logic n_match;

    // Prefix extends by one byte when the neighbor matched and this byte agrees
    assign o_hit = i_prev_match && (i_data_byte == i_pattern_byte);

    always_comb begin
        n_match = r_match;
        if (i_clear) begin
            n_match = 1'b0;
        end else if (i_step) begin
            n_match = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;

endmodule
